// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the id set.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcis_pkg.sv =====
// Package of the reference-counted id set: widths, defaults, codes, types.
// Used by the interfaces, the datapath unit, the top level and the checker.
`timescale 1ns / 1ps

package rcis_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int ID_W        = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int COUNT_OUT_W = 16;
    localparam int OCC_OUT_W   = 5;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_RAISED  = 3'd1,
        ST_LOWERED = 3'd2,
        ST_FREED   = 3'd3,
        ST_MISS    = 3'd4
    } t_status;

    typedef struct packed {
        logic match;
        logic frees;
    } t_unit_flags;

endpackage

// ===== design/rcis_if.sv =====
// Valid/ready channel interfaces for the id set: request and result.
// Depends on rcis_pkg for the field widths.
`timescale 1ns / 1ps

interface rcis_in_if import rcis_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [ID_W-1:0] body_id;

    modport source (output valid, output func, output body_id, input ready);
    modport sink   (input valid, input func, input body_id, output ready);
endinterface

interface rcis_out_if import rcis_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] count_after;
    logic [OCC_OUT_W-1:0]   occupancy;
    logic                   dropped_full;

    modport source (output valid, output status, output slot, output count_after,
                    output occupancy, output dropped_full, input ready);
    modport sink   (input valid, input status, input slot, input count_after,
                    input occupancy, input dropped_full, output ready);
endinterface

// ===== design/reference_counted_id_set.sv =====
// Top level of the reference-counted id set: sequencer, table RAM, result register.
// Depends on rcis_pkg, rcis_if, rcis_ram and rcis_unit.
//
//   port   | dir | handshake   | transfer
//   i_in   | in  | valid/ready | func, body_id
//   o_out  | out | valid/ready | status, slot, count_after, occupancy, dropped_full
//
// An item scans the live slots from slot 0 and stops early on a match (an empty table skips
// the scan); freeing an entry adds a fetch and a move of the last entry; the scan reads
// one RAM slot a cycle through the single read port.
// An item is taken only in the idle state; one result may wait in the output
// register while the next item scans, and the final step holds while that register is full.
// Synchronous active-low reset empties the table.
`timescale 1ns / 1ps

module reference_counted_id_set import rcis_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    rcis_in_if.sink     i_in,
    rcis_out_if.source  o_out
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int RAM_W = ID_W + COUNT_BITS;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_RESOLVE = 5'b00100,
        S_FETCH   = 5'b01000,
        S_MOVE    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_func, n_func;
    logic [ID_W-1:0] r_id, n_id;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [IDX_W-1:0] r_cmp_addr, n_cmp_addr;
    logic   r_issue, n_issue;
    logic   r_pend, n_pend;
    logic   r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_slot, n_hit_slot;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic [OCC_W-1:0] r_live, n_live;

    logic   r_out_valid, n_out_valid;
    t_status r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [COUNT_OUT_W-1:0] r_out_cnt;
    logic [OCC_OUT_W-1:0] r_out_occ;
    logic   r_out_drop;

    logic                  w_emit;
    t_status               n_out_status;
    logic [IDX_W-1:0]      n_out_slot;
    logic [COUNT_BITS-1:0] n_out_cnt;
    logic                  n_out_drop;
    logic [31:0]           w_slot_wide, w_cnt_wide, w_occ_wide;

    logic             w_ram_we, w_ram_re;
    logic [IDX_W-1:0] w_ram_waddr, w_ram_raddr;
    logic [RAM_W-1:0] w_ram_wdata, w_ram_rdata;
    logic [ID_W-1:0]  w_rd_id;
    logic [COUNT_BITS-1:0] w_rd_cnt, w_cnt_next;
    t_unit_flags      w_flags;

    logic [IDX_W-1:0] w_last;
    logic             w_full, w_out_free;

    assign w_rd_id    = w_ram_rdata[RAM_W-1 -: ID_W];
    assign w_rd_cnt   = w_ram_rdata[COUNT_BITS-1:0];
    assign w_last     = IDX_W'(r_live - OCC_W'(1));
    assign w_full     = (r_live == OCC_W'(ENTRIES));
    assign w_out_free = !r_out_valid || o_out.ready;

    rcis_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    rcis_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .i_key        (r_id),
        .i_entry_id   (w_rd_id),
        .i_count      (r_hit_cnt),
        .i_remove     (r_func == FUNC_REMOVE),
        .o_flags      (w_flags),
        .o_count_next (w_cnt_next)
    );

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_id         = r_id;
        n_addr       = r_addr;
        n_cmp_addr   = r_cmp_addr;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_hit        = r_hit;
        n_hit_slot   = r_hit_slot;
        n_hit_cnt    = r_hit_cnt;
        n_live       = r_live;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_hit_slot;
        w_ram_wdata  = {r_id, w_cnt_next};
        w_ram_re     = 1'b0;
        w_ram_raddr  = r_addr;
        w_emit       = 1'b0;
        n_out_status = ST_MISS;
        n_out_slot   = '0;
        n_out_cnt    = '0;
        n_out_drop   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_id    = i_in.body_id;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                    n_state = (r_live == '0) ? S_RESOLVE : S_SCAN;
                end
            end
            S_SCAN: begin
                w_ram_re    = r_issue;
                w_ram_raddr = r_addr;
                n_pend      = r_issue;
                n_cmp_addr  = r_addr;
                if (r_issue) begin
                    if (r_addr == w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (r_pend && w_flags.match) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_cmp_addr;
                    n_hit_cnt  = w_rd_cnt;
                    n_state    = S_RESOLVE;
                end else if (r_pend && !r_issue) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                priority if (r_hit && r_func == FUNC_REMOVE && w_flags.frees) begin
                    n_state = S_FETCH;
                end else if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    priority if (r_hit) begin
                        w_ram_we     = 1'b1;
                        w_ram_waddr  = r_hit_slot;
                        w_ram_wdata  = {r_id, w_cnt_next};
                        n_out_status = (r_func == FUNC_ADD) ? ST_RAISED : ST_LOWERED;
                        n_out_slot   = r_hit_slot;
                        n_out_cnt    = w_cnt_next;
                    end else if (r_func == FUNC_ADD && !w_full) begin
                        w_ram_we     = 1'b1;
                        w_ram_waddr  = IDX_W'(r_live);
                        w_ram_wdata  = {r_id, COUNT_BITS'(1)};
                        n_out_status = ST_NEW;
                        n_out_slot   = IDX_W'(r_live);
                        n_out_cnt    = COUNT_BITS'(1);
                        n_live       = r_live + OCC_W'(1);
                    end else begin
                        n_out_status = ST_MISS;
                        n_out_drop   = (r_func == FUNC_ADD);
                    end
                end
            end
            S_FETCH: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_last;
                n_state     = S_MOVE;
            end
            S_MOVE: begin
                if (w_out_free) begin
                    w_ram_we     = 1'b1;
                    w_ram_waddr  = r_hit_slot;
                    w_ram_wdata  = w_ram_rdata;
                    n_live       = r_live - OCC_W'(1);
                    w_emit       = 1'b1;
                    n_out_status = ST_FREED;
                    n_out_slot   = r_hit_slot;
                    n_out_cnt    = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_slot_wide = 32'(n_out_slot);
    assign w_cnt_wide  = 32'(n_out_cnt);
    assign w_occ_wide  = 32'(n_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_id       <= n_id;
        r_addr     <= n_addr;
        r_cmp_addr <= n_cmp_addr;
        r_hit_slot <= n_hit_slot;
        r_hit_cnt  <= n_hit_cnt;
        if (w_emit) begin
            r_out_status <= n_out_status;
            r_out_slot   <= w_slot_wide[SLOT_W-1:0];
            r_out_cnt    <= w_cnt_wide[COUNT_OUT_W-1:0];
            r_out_occ    <= w_occ_wide[OCC_OUT_W-1:0];
            r_out_drop   <= n_out_drop;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.slot         = r_out_slot;
    assign o_out.count_after  = r_out_cnt;
    assign o_out.occupancy    = r_out_occ;
    assign o_out.dropped_full = r_out_drop;

endmodule

// ===== design/rcis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module rcis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rcis_unit.sv =====
// Shared compare and count-adjust unit of the id set.
// Depends on rcis_pkg.
`timescale 1ns / 1ps

module rcis_unit import rcis_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [ID_W-1:0]       i_key,
    input  logic [ID_W-1:0]       i_entry_id,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic                  i_remove,
    output t_unit_flags           o_flags,
    output logic [COUNT_BITS-1:0] o_count_next
);

    always_comb begin
        o_flags.match = (i_key == i_entry_id);
        o_flags.frees = (i_count[COUNT_BITS-1:1] == '0);
        if (i_remove) begin
            o_count_next = i_count - COUNT_BITS'(1);
        end else if (&i_count) begin
            o_count_next = i_count;
        end else begin
            o_count_next = i_count + COUNT_BITS'(1);
        end
    end

endmodule

// ===== design/rcis_checker.sv =====
// Port-level checker of the id set, bound to the top level.
// Depends on rcis_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcis_checker import rcis_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_W-1:0]    i_status,
    input logic [COUNT_OUT_W-1:0] i_count_after,
    input logic [OCC_OUT_W-1:0]   i_occupancy,
    input logic                   i_dropped_full
);

    localparam logic [31:0] ENT_WIDE = 32'(ENTRIES);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")
    `ASSERT_IMP(a_new_count, i_clk, i_rst_n, i_out_valid && i_status == ST_NEW, i_count_after == COUNT_OUT_W'(1) && !i_dropped_full, "new entry count not one")
    `ASSERT_IMP(a_drop_full, i_clk, i_rst_n, i_out_valid && i_dropped_full, i_status == ST_MISS && i_occupancy == ENT_WIDE[OCC_OUT_W-1:0], "drop without full table")
    `ASSERT_IMP(a_freed_zero, i_clk, i_rst_n, i_out_valid && i_status == ST_FREED, i_count_after == '0 && !i_dropped_full, "freed entry count not zero")

endmodule

bind reference_counted_id_set rcis_checker #(
    .ENTRIES (ENTRIES)
) u_rcis_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_count_after  (o_out.count_after),
    .i_occupancy    (o_out.occupancy),
    .i_dropped_full (o_out.dropped_full)
);
